// File: rtl/core/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the demapper RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with active-low synchronous reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Shorthand for the aclk / aresetn domain.
`define ASSERT_ACLK(label, prop, msg) `ASSERT_SYNC(label, aclk, aresetn, prop, msg)

`endif

// File: rtl/core/msbd_pkg.sv
// msbd_pkg: shared constants, register codes and structs of the max-log demapper.
// No dependencies.
package msbd_pkg;

    localparam int LLR_W      = 16;  // signed Q8.8 LLR
    localparam int CLIP_W     = 15;
    localparam int SCALE_W    = 16;  // unsigned Q8.8
    localparam int VAR_W      = 16;  // unsigned Q8.8
    localparam int QUO_W      = CLIP_W;  // quotient bits kept before saturation
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int Q_DEPTH    = 2;   // symbols buffered between front and back

    localparam logic [SCALE_W-1:0] LLR_SCALE_RST      = 16'd1536;  // 6.0
    localparam logic [SCALE_W-1:0] ADAPTIVE_SCALE_RST = 16'd256;   // 1.0
    localparam logic [VAR_W-1:0]   NOISE_VAR_RST      = 16'd256;   // 1.0
    localparam logic [CLIP_W-1:0]  LLR_CLIP_RST       = 15'd2048;  // 8.0
    localparam logic [VAR_W-1:0]   VAR_FLOOR          = 16'd128;   // 0.5
    localparam logic [VAR_W-1:0]   UNIT_DIVISOR       = 16'd256;   // 1.0

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LLR_SCALE      = 3'd0,
        REG_ADAPTIVE_SCALE = 3'd1,
        REG_USE_ADAPTIVE   = 3'd2,
        REG_USE_VARIANCE   = 3'd3,
        REG_NOISE_VARIANCE = 3'd4,
        REG_LLR_CLIP       = 3'd5
    } msbd_reg_idx_t;

    // Resolved settings handed to the back end.
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [VAR_W-1:0]   divisor;
        logic [CLIP_W-1:0]  clip;
    } msbd_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } msbd_q_status_t;

endpackage

// File: rtl/core/msbd_front.sv
// msbd_front: accepts metric beats, Gray-decodes the index and tracks per-bit maxima.
// On the last beat pushes the updated maxima into the queue. Depends on msbd_pkg.
module msbd_front #(
    parameter int BPS = 4,
    parameter int MW  = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [BPS-1:0]           in_index,
    input  logic signed [MW-1:0]     in_metric,
    input  logic                     in_last,
    input  msbd_pkg::msbd_q_status_t q_status,
    output logic                     q_push,
    output logic [2*BPS*MW-1:0]      q_data
);
    import msbd_pkg::*;

    localparam logic signed [MW-1:0] FLOOR = {1'b1, {(MW-1){1'b0}}};

    logic signed [MW-1:0] best0_reg [BPS];
    logic signed [MW-1:0] best1_reg [BPS];
    logic signed [MW-1:0] best0_next [BPS];
    logic signed [MW-1:0] best1_next [BPS];
    logic signed [MW-1:0] upd0 [BPS];
    logic signed [MW-1:0] upd1 [BPS];
    logic [BPS-1:0]       bin;
    logic                 accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && in_last;

    always_comb begin
        for (int k = 0; k < BPS; k++) begin
            bin[k] = ^(in_index >> k);
        end
        for (int b = 0; b < BPS; b++) begin
            // position 0 is the most significant binary bit
            upd0[b] = (!bin[BPS-1-b] && (in_metric > best0_reg[b])) ? in_metric : best0_reg[b];
            upd1[b] = (bin[BPS-1-b] && (in_metric > best1_reg[b])) ? in_metric : best1_reg[b];
            best0_next[b] = best0_reg[b];
            best1_next[b] = best1_reg[b];
            if (accept) begin
                best0_next[b] = in_last ? FLOOR : upd0[b];
                best1_next[b] = in_last ? FLOOR : upd1[b];
            end
            q_data[b*2*MW +: MW]      = upd0[b];
            q_data[b*2*MW + MW +: MW] = upd1[b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < BPS; b++) begin
                best0_reg[b] <= FLOOR;
                best1_reg[b] <= FLOOR;
            end
        end else begin
            best0_reg <= best0_next;
            best1_reg <= best1_next;
        end
    end

endmodule

// File: rtl/core/msbd_fifo.sv
// msbd_fifo: short queue of per-symbol maxima between front and back end.
// Registered read data holds until the next pop. Depends on msbd_pkg.
module msbd_fifo #(
    parameter int DATA_W = 128,
    parameter int DEPTH  = 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     pop,
    output logic [DATA_W-1:0]        rd_data,
    output msbd_pkg::msbd_q_status_t status
);
    import msbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] rd_data_reg;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_data      = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (pop) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/msbd_back.sv
// msbd_back: per-bit LLR engine: difference, scale multiply, restoring divide by the
// configured divisor with round-half-up, clip, and the output register. Depends on msbd_pkg.
module msbd_back #(
    parameter int BPS   = 4,
    parameter int MW    = 16,
    parameter int POS_W = 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  msbd_pkg::msbd_cfg_t         cfg,
    input  msbd_pkg::msbd_q_status_t    q_status,
    output logic                        q_pop,
    input  logic [2*BPS*MW-1:0]         q_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [POS_W-1:0]            out_pos,
    output logic [msbd_pkg::LLR_W-1:0]  out_llr,
    output logic                        out_clipped,
    output logic                        out_final
);
    import msbd_pkg::*;

    localparam int PROD_W = MW + SCALE_W;
    localparam int WIDE_W = (PROD_W + 1 > VAR_W + QUO_W) ? PROD_W + 1 : VAR_W + QUO_W;
    localparam int ITER_W = $clog2(QUO_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_NUM,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               neg_reg;
    logic [MW-1:0]      mag_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [WIDE_W-1:0]  rem_reg;
    logic [WIDE_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic               ovf_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [LLR_W-1:0]   out_llr_reg;
    logic               out_clip_reg;
    logic               out_final_reg;

    logic signed [MW-1:0] sel0, sel1;
    logic signed [MW:0]   diff, diff_neg;
    logic [MW-1:0]        mag;
    logic [PROD_W-1:0]    prod;
    logic [WIDE_W-1:0]    num, limit, trial;
    logic                 ge, over, is_last_pos, out_free, clip_hit, emit;
    logic [QUO_W-1:0]     mag_out;
    logic [LLR_W-1:0]     llr_pos;

    always_comb begin
        sel0     = q_data[int'(pos_reg)*2*MW +: MW];
        sel1     = q_data[int'(pos_reg)*2*MW + MW +: MW];
        diff     = {sel0[MW-1], sel0} - {sel1[MW-1], sel1};
        diff_neg = -diff;
        mag      = diff[MW] ? diff_neg[MW-1:0] : diff[MW-1:0];
        prod     = mag_reg * cfg.scale;
        // rounding half: divisor/2 added before the divide
        num      = WIDE_W'(prod_reg) + WIDE_W'(cfg.divisor >> 1);
        limit    = WIDE_W'(cfg.divisor) << QUO_W;
        over     = (num >= limit);
        ge       = (rem_reg >= dsh_reg);
        trial    = rem_reg - dsh_reg;
        clip_hit = ovf_reg || (quo_reg >= cfg.clip);
        mag_out  = clip_hit ? cfg.clip : quo_reg;
        llr_pos  = {1'b0, mag_out};
        is_last_pos = (pos_reg == POS_W'(BPS - 1));
        out_free = !out_valid_reg || out_ready;
        emit     = (state_reg == ST_EMIT) && out_free;
    end

    assign q_pop       = (state_reg == ST_IDLE) && !q_status.empty;
    assign out_valid   = out_valid_reg;
    assign out_pos     = out_pos_reg;
    assign out_llr     = out_llr_reg;
    assign out_clipped = out_clip_reg;
    assign out_final   = out_final_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= emit || (out_valid_reg && !out_ready);
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_status.empty) begin
                        pos_reg   <= '0;
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    neg_reg   <= diff[MW];
                    mag_reg   <= mag;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= prod;
                    state_reg <= ST_NUM;
                end
                ST_NUM: begin
                    rem_reg   <= num;
                    ovf_reg   <= over;
                    dsh_reg   <= WIDE_W'(cfg.divisor) << (QUO_W - 1);
                    quo_reg   <= '0;
                    iter_reg  <= '0;
                    // quotient too wide for QUO_W bits, so beyond any clip: skip the divide
                    state_reg <= over ? ST_EMIT : ST_DIV;
                end
                ST_DIV: begin
                    if (ge) begin
                        rem_reg <= trial;
                    end
                    quo_reg  <= {quo_reg[QUO_W-2:0], ge};
                    dsh_reg  <= dsh_reg >> 1;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(QUO_W - 1)) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_pos_reg   <= pos_reg;
                        out_llr_reg   <= neg_reg ? -llr_pos : llr_pos;
                        out_clip_reg  <= clip_hit;
                        out_final_reg <= is_last_pos;
                        if (is_last_pos) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            pos_reg   <= pos_reg + 1'b1;
                            state_reg <= ST_DIFF;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/maxlog_soft_bit_demapper.sv
// maxlog_soft_bit_demapper: max-log LLR demapper, top level. Uses msbd_pkg, msbd_front,
// msbd_fifo, msbd_back and assert_macros.svh.
// Metrics enter one per beat while the queue is not full; the back end handles one symbol
// at a time, bit by bit through the 15-step serial divider, with up to two symbols queued.
// The divide is skipped when the quotient overflows, so a saturating bit leaves sooner.
// aresetn (synchronous, active low) restores register defaults and clears all maxima.
`include "assert_macros.svh"

module maxlog_soft_bit_demapper #(
    parameter int SYM_BITS     = 4,
    parameter int METRIC_WIDTH = 16,
    localparam int POS_W     = $clog2(SYM_BITS),
    localparam int S_TDATA_W = ((SYM_BITS + METRIC_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((POS_W + msbd_pkg::LLR_W + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [msbd_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [msbd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,   // symbol_index, metric_value, zero pad
    input  logic                             s_tlast,   // last_metric
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [M_TDATA_W-1:0]             m_tdata,   // bit_position, llr_value, zero pad
    output logic                             m_tuser,   // clipped
    output logic                             m_tlast    // final_bit
);
    import msbd_pkg::*;

    localparam int BPS     = SYM_BITS;
    localparam int MW      = METRIC_WIDTH;
    localparam int ENTRY_W = 2 * BPS * MW;

    logic [SCALE_W-1:0] llr_scale_reg;
    logic [SCALE_W-1:0] adaptive_scale_reg;
    logic               use_adaptive_reg;
    logic               use_variance_reg;
    logic [VAR_W-1:0]   noise_var_reg;
    logic [CLIP_W-1:0]  llr_clip_reg;
    msbd_cfg_t          cfg_reg, cfg_next;

    logic [2*SCALE_W-1:0] adapt_prod;
    logic [2*SCALE_W:0]   adapt_round;
    logic [2*SCALE_W-8:0] adapt_q;

    msbd_q_status_t       q_status;
    logic                 q_push, q_pop;
    logic [ENTRY_W-1:0]   q_wr_data, q_rd_data;
    logic [POS_W-1:0]     out_pos;
    logic [LLR_W-1:0]     out_llr;
    logic [LLR_W-1:0]     clip_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            llr_scale_reg      <= LLR_SCALE_RST;
            adaptive_scale_reg <= ADAPTIVE_SCALE_RST;
            use_adaptive_reg   <= 1'b0;
            use_variance_reg   <= 1'b1;
            noise_var_reg      <= NOISE_VAR_RST;
            llr_clip_reg       <= LLR_CLIP_RST;
        end else if (cfg_wr_en) begin
            unique case (msbd_reg_idx_t'(cfg_wr_index))
                REG_LLR_SCALE:      llr_scale_reg      <= cfg_wr_data[SCALE_W-1:0];
                REG_ADAPTIVE_SCALE: adaptive_scale_reg <= cfg_wr_data[SCALE_W-1:0];
                REG_USE_ADAPTIVE:   use_adaptive_reg   <= cfg_wr_data[0];
                REG_USE_VARIANCE:   use_variance_reg   <= cfg_wr_data[0];
                REG_NOISE_VARIANCE: noise_var_reg      <= cfg_wr_data[VAR_W-1:0];
                REG_LLR_CLIP:       llr_clip_reg       <= cfg_wr_data[CLIP_W-1:0];
                default: ;
            endcase
        end
    end

    // With adaptive on, scale is (scale * adaptive + 0.5 lsb) >> 8, saturated to 16 bits.
    always_comb begin
        adapt_prod  = llr_scale_reg * adaptive_scale_reg;
        adapt_round = {1'b0, adapt_prod} + (2*SCALE_W+1)'(128);
        adapt_q     = adapt_round[2*SCALE_W:8];
        cfg_next.scale = llr_scale_reg;
        if (use_adaptive_reg) begin
            cfg_next.scale = (|adapt_q[2*SCALE_W-8:SCALE_W]) ? '1 : adapt_q[SCALE_W-1:0];
        end
        if (use_variance_reg) begin
            cfg_next.divisor = (noise_var_reg < VAR_FLOOR) ? VAR_FLOOR : noise_var_reg;
        end else begin
            cfg_next.divisor = UNIT_DIVISOR;
        end
        cfg_next.clip = llr_clip_reg;
    end

    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
    end

    msbd_front #(
        .BPS (BPS),
        .MW  (MW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_index  (s_tdata[BPS-1:0]),
        .in_metric (s_tdata[BPS+MW-1:BPS]),
        .in_last   (s_tlast),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    msbd_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (Q_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    msbd_back #(
        .BPS   (BPS),
        .MW    (MW),
        .POS_W (POS_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .q_data      (q_rd_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pos     (out_pos),
        .out_llr     (out_llr),
        .out_clipped (m_tuser),
        .out_final   (m_tlast)
    );

    assign m_tdata  = M_TDATA_W'({out_llr, out_pos});
    assign clip_ext = {1'b0, cfg_reg.clip};

    `ASSERT_ACLK(a_q_no_overflow, q_push |-> !q_status.full, "symbol pushed into full queue")
    `ASSERT_ACLK(a_q_no_underflow, q_pop |-> !q_status.empty, "pop from empty queue")
    `ASSERT_ACLK(a_last_pos, m_tvalid && m_tlast |-> out_pos == POS_W'(BPS - 1), "tlast on wrong bit")
    `ASSERT_ACLK(a_clip_mag, m_tvalid && m_tuser |-> (out_llr == clip_ext || out_llr == -clip_ext), "clipped LLR not at limit")

endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for maxlog_soft_bit_demapper (max-log Gray 16-ary LLR demapper).
// Depends on msbd_pkg and the demapper RTL; predicts LLRs in-line and checks every output beat.
`timescale 1ns / 100ps

module testbench;
    import msbd_pkg::*;

    localparam int S_W = 24;   // symbol_index[3:0], metric_value[19:4], pad
    localparam int M_W = 24;   // bit_position[1:0], llr_value[17:2], pad
    localparam logic signed [15:0] METRIC_MIN = 16'sh8000;
    localparam int LONG_HOLD_AT  = 17;  // first LLR after the directed symbols
    localparam int LONG_HOLD_LEN = 600;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [3:0]         sym;
        logic signed [15:0] metric;
        logic               is_last;
        int                 gap;
    } metric_beat_t;

    typedef struct {
        logic [1:0]  pos;
        logic [15:0] llr;
        logic        clipped;
        logic        final_flag;
    } llr_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    maxlog_soft_bit_demapper dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow registers and running maxima of the predictor
    logic [15:0] sh_scale = LLR_SCALE_RST;
    logic [15:0] sh_adaptive = ADAPTIVE_SCALE_RST;
    logic        sh_use_adaptive = 1'b0;
    logic        sh_use_variance = 1'b1;
    logic [15:0] sh_noise_var = NOISE_VAR_RST;
    logic [14:0] sh_clip = LLR_CLIP_RST;
    logic signed [15:0] best_zero[4] = '{METRIC_MIN, METRIC_MIN, METRIC_MIN, METRIC_MIN};
    logic signed [15:0] best_one[4]  = '{METRIC_MIN, METRIC_MIN, METRIC_MIN, METRIC_MIN};

    metric_beat_t pending_beats[$];
    llr_result_t  expected_llrs[$];
    metric_beat_t in_flight;
    int gap_waited = 0;
    int rx_wait = 0;
    int beats_sent = 0;
    int llrs_checked = 0;
    int symbols_closed = 0;
    int settings_used = 1;
    int fail_count = 0;

    // Absorb one metric into the maxima; on the last beat emit the four LLRs.
    function automatic void absorb_metric(metric_beat_t bt);
        logic [3:0] bin;
        longint eff_scale, divisor, diff, mag, q, val;
        llr_result_t r;
        bin = bt.sym ^ (bt.sym >> 1) ^ (bt.sym >> 2) ^ (bt.sym >> 3);
        for (int b = 0; b < 4; b++) begin
            if (bin[3-b]) begin
                if (bt.metric > best_one[b]) best_one[b] = bt.metric;
            end else begin
                if (bt.metric > best_zero[b]) best_zero[b] = bt.metric;
            end
        end
        if (!bt.is_last) return;
        eff_scale = longint'(sh_scale);
        if (sh_use_adaptive) begin
            eff_scale = (longint'(sh_scale) * longint'(sh_adaptive) + 128) >> 8;
            if (eff_scale > 65535) eff_scale = 65535;
        end
        if (!sh_use_variance)
            divisor = longint'(UNIT_DIVISOR);
        else if (sh_noise_var < VAR_FLOOR)
            divisor = longint'(VAR_FLOOR);
        else
            divisor = longint'(sh_noise_var);
        for (int b = 0; b < 4; b++) begin
            diff = longint'(best_zero[b]) - longint'(best_one[b]);
            mag = (diff < 0) ? -diff : diff;
            q = (mag * eff_scale + divisor / 2) / divisor;
            r.clipped = (q >= longint'(sh_clip));
            val = r.clipped ? longint'(sh_clip) : q;
            if (diff < 0) val = -val;
            r.pos = 2'(b);
            r.llr = val[15:0];
            r.final_flag = (b == 3);
            expected_llrs.insert(expected_llrs.size(), r);
        end
        for (int b = 0; b < 4; b++) begin
            best_zero[b] = METRIC_MIN;
            best_one[b] = METRIC_MIN;
        end
        symbols_closed++;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] pick_metric();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1023) - 512);
            2: case ($urandom_range(0, 2))
                   0: return 16'sh7fff;
                   1: return 16'sh8000;
                   default: return 16'sh0000;
               endcase
            default: return 16'(16'sh7f00 + $urandom_range(0, 255));
        endcase
    endfunction

    // Driver: one beat in flight, next one taken from pending_beats after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_metric(in_flight);
                beats_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && gap_waited >= pending_beats[0].gap) begin
                    in_flight = pending_beats.pop_front();
                    gap_waited = 0;
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0000, in_flight.metric, in_flight.sym};
                    s_tlast <= in_flight.is_last;
                end else begin
                    if (pending_beats.size() != 0) gap_waited++;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each LLR beat with the oldest prediction, then pick a stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_llrs.size() == 0) begin
                    $error("LLR beat with nothing expected: tdata=%h", m_tdata);
                    fail_count++;
                end else begin
                    llr_result_t e;
                    e = expected_llrs.pop_front();
                    if (m_tdata[1:0] !== e.pos) begin
                        $error("bit_position: expected %0d, got %0d", e.pos, m_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_tdata[17:2] !== e.llr) begin
                        $error("llr_value: expected %0d, got %0d",
                               $signed(e.llr), $signed(m_tdata[17:2]));
                        fail_count++;
                    end
                    if (m_tuser !== e.clipped) begin
                        $error("clipped: expected %0b, got %0b", e.clipped, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== e.final_flag) begin
                        $error("final_bit: expected %0b, got %0b", e.final_flag, m_tlast);
                        fail_count++;
                    end
                end
                llrs_checked++;
                // long hold-off so the input side backs up
                if (llrs_checked == LONG_HOLD_AT)
                    rx_wait = LONG_HOLD_LEN;
                else if (llrs_checked % 24 < 8)
                    rx_wait = 0;
                else
                    rx_wait = pick_gap();
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(msbd_reg_idx_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LLR_SCALE:      sh_scale = val;
            REG_ADAPTIVE_SCALE: sh_adaptive = val;
            REG_USE_ADAPTIVE:   sh_use_adaptive = val[0];
            REG_USE_VARIANCE:   sh_use_variance = val[0];
            REG_NOISE_VARIANCE: sh_noise_var = val;
            REG_LLR_CLIP:       sh_clip = val[14:0];
            default: ;
        endcase
    endtask

    task automatic push_beat(logic [3:0] sym, logic signed [15:0] metric, logic is_last,
                             int gap);
        metric_beat_t bt;
        bt.sym = sym;
        bt.metric = metric;
        bt.is_last = is_last;
        bt.gap = gap;
        pending_beats.insert(pending_beats.size(), bt);
    endtask

    // Mostly full symbols (16 distinct indices); the rest short symbols with
    // repeated indices or a run with its last flag dropped. Ends on a last beat.
    task automatic queue_phase(int n_items, bit tidy_only);
        int left, kind, len, k, tmp;
        int order[16];
        bit quiet, drop_last;
        left = n_items;
        while (left > 0) begin
            kind = tidy_only ? 0 : $urandom_range(0, 9);
            len = (kind < 7 || kind == 9) ? 16 : $urandom_range(1, 8);
            if (len > left) len = left;
            drop_last = (kind == 9) && (len < left);
            for (int j = 0; j < 16; j++) order[j] = j;
            for (int j = 15; j > 0; j--) begin
                k = $urandom_range(0, j);
                tmp = order[j];
                order[j] = order[k];
                order[k] = tmp;
            end
            quiet = tidy_only || ($urandom_range(0, 3) == 0);
            for (int j = 0; j < len; j++)
                push_beat((kind >= 7 && kind < 9) ? 4'($urandom_range(0, 15)) : 4'(order[j]),
                          pick_metric(), (j == len - 1) && !drop_last,
                          quiet ? 0 : pick_gap());
            left -= len;
        end
    endtask

    // Sender holds until every predicted LLR is out, then lets the back end settle
    task automatic drain();
        while (pending_beats.size() != 0 || s_tvalid || expected_llrs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every index once with extreme metrics, lone beats, repeated index
        for (int i = 0; i < 16; i++)
            push_beat(4'(i), (i == 0) ? 16'sh7fff : (i == 1) ? 16'sh8000 : 16'(i * 1000 - 7000),
                      i == 15, 0);
        push_beat(4'd15, 16'sh7fff, 1'b1, 2);
        push_beat(4'd0, 16'sh8000, 1'b1, 0);
        push_beat(4'd5, 16'sh0064, 1'b0, 0);
        push_beat(4'd5, 16'sh012c, 1'b0, 1);
        push_beat(4'd10, -16'sd5, 1'b1, 0);
        drain();

        // Full scale, variance below floor, widest clip; long receiver hold here
        write_reg(REG_LLR_SCALE, 16'hffff);
        write_reg(REG_NOISE_VARIANCE, 16'h0000);
        write_reg(REG_LLR_CLIP, 16'h7fff);
        settings_used++;
        queue_phase(64, 1'b1);
        drain();

        // Zero clip
        write_reg(REG_LLR_CLIP, 16'h0000);
        settings_used++;
        queue_phase(26, 1'b0);
        drain();

        // Adaptive scale saturating, unit divisor
        write_reg(REG_USE_VARIANCE, 16'h0000);
        write_reg(REG_USE_ADAPTIVE, 16'h0001);
        write_reg(REG_ADAPTIVE_SCALE, 16'hffff);
        write_reg(REG_LLR_CLIP, 16'h7fff);
        settings_used++;
        queue_phase(26, 1'b0);
        drain();

        // Adaptive factor zero: every LLR collapses to zero
        write_reg(REG_ADAPTIVE_SCALE, 16'h0000);
        settings_used++;
        queue_phase(26, 1'b0);
        drain();

        // Random setting
        write_reg(REG_LLR_SCALE, 16'($urandom));
        write_reg(REG_ADAPTIVE_SCALE, 16'($urandom_range(0, 1023)));
        write_reg(REG_USE_ADAPTIVE, 16'($urandom_range(0, 1)));
        write_reg(REG_USE_VARIANCE, 16'($urandom_range(0, 1)));
        write_reg(REG_NOISE_VARIANCE, 16'($urandom));
        write_reg(REG_LLR_CLIP, 16'($urandom_range(0, 32767)));
        settings_used++;
        queue_phase(26, 1'b0);
        drain();

        // Default scale and clip, largest variance
        write_reg(REG_LLR_SCALE, LLR_SCALE_RST);
        write_reg(REG_USE_ADAPTIVE, 16'h0000);
        write_reg(REG_USE_VARIANCE, 16'h0001);
        write_reg(REG_NOISE_VARIANCE, 16'hffff);
        write_reg(REG_LLR_CLIP, 16'(LLR_CLIP_RST));
        settings_used++;
        queue_phase(26, 1'b0);
        drain();

        $display("covered %0d metric beats in %0d symbols, %0d LLR beats checked,",
                 beats_sent, symbols_closed, llrs_checked);
        $display("across %0d register settings incl. zero clip, variance floor, sat. scale",
                 settings_used);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout waiting for demapper output");
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/msbd_pkg.sv
rtl/core/msbd_front.sv
rtl/core/msbd_fifo.sv
rtl/core/msbd_back.sv
rtl/core/maxlog_soft_bit_demapper.sv
tb/testbench.sv
